// ----- rtl/core/lglg_pkg.sv -----
// Shared types and constants for the literal line grep unit.
// No dependencies; used by every module under rtl/core.
package lglg_pkg;

   localparam int LINE_MAX     = 63;
   localparam int PAT_MAX      = 16;
   localparam int RESULT_LIMIT = 64;
   localparam int LINE_IDX_W   = $clog2(LINE_MAX);
   localparam int PAT_IDX_W    = $clog2(PAT_MAX);
   localparam int PAT_LEN_W    = 5;

   localparam logic [7:0] NEWLINE = 8'h0A;

   // request op codes (req_tuser)
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_PAT_LOW  = 2'd0;
   localparam logic [1:0] CSR_PAT_HIGH = 2'd1;
   localparam logic [1:0] CSR_PAT_LEN  = 2'd2;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_DROP    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef logic [PAT_MAX-1:0][7:0] pat_type;

   // control broadcast to the window chain
   typedef struct packed {
      logic       shift;
      logic       clear;
      logic [7:0] data;
   } win_ctl_type;

endpackage

// ----- rtl/core/lglg_cell.sv -----
// One window cell: holds one recent byte and compares its next value with
// the pattern byte that lines up with it. Depends on lglg_pkg.
module lglg_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift,
   input  logic                           clear,
   input  logic [7:0]                     d_in,
   input  logic [lglg_pkg::PAT_IDX_W-1:0] cell_idx,
   input  lglg_pkg::pat_type              pat,
   input  logic [lglg_pkg::PAT_LEN_W-1:0] plen,
   output logic [7:0]                     q,
   output logic                           ok
);
   import lglg_pkg::*;

   logic [7:0]           byte_ff;
   logic [7:0]           byte_in;
   logic [PAT_LEN_W-1:0] sel;

   // cell i lines up with pattern byte plen-1-i
   assign sel = plen - PAT_LEN_W'(1) - PAT_LEN_W'(cell_idx);
   assign ok  = (PAT_LEN_W'(cell_idx) >= plen) || (d_in == pat[sel[PAT_IDX_W-1:0]]);

   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = 8'h00;
      end else if (shift) begin
         byte_in = d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign q = byte_ff;

endmodule

// ----- rtl/core/lglg_window.sv -----
// Chain of window cells holding the newest bytes of the current line.
// Depends on lglg_pkg and lglg_cell.
module lglg_window (
   input  logic                           clock,
   input  logic                           reset,
   input  lglg_pkg::win_ctl_type          ctl,
   input  lglg_pkg::pat_type              pat,
   input  logic [lglg_pkg::PAT_LEN_W-1:0] plen,
   output logic                           all_ok
);
   import lglg_pkg::*;

   logic [PAT_MAX-1:0][7:0] q;
   logic [PAT_MAX-1:0][7:0] d;
   logic [PAT_MAX-1:0]      ok;

   genvar i;
   generate
      for (i = 0; i < PAT_MAX; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign d[i] = ctl.data;
         end else begin : g_link
            assign d[i] = q[i-1];
         end
         lglg_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (ctl.shift),
            .clear    (ctl.clear),
            .d_in     (d[i]),
            .cell_idx (PAT_IDX_W'(i)),
            .pat      (pat),
            .plen     (plen),
            .q        (q[i]),
            .ok       (ok[i])
         );
      end
   endgenerate

   assign all_ok = &ok;

endmodule

// ----- rtl/core/literal_line_grep_unit.sv -----
// Literal line grep top level: stream in, matching lines out.
// Depends on lglg_pkg and lglg_window (which uses lglg_cell).
//
// Bytes arrive one per req transaction (req_tuser = 0) and are cut into lines
// at newline. Each accepted data byte shifts into a chain of 16 window cells
// that compare against the configured pattern in that same cycle, and is
// written into a 63-byte line store. A newline on a matching line replays
// the line from the store, each stored byte through a registered single-port
// read and then a load into the output register, followed by the newline;
// a matching line longer than 63 bytes yields a single dropped transaction
// instead. An end-of-input transaction (req_tuser = 1) finishes a pending
// matching line the same way (newline appended; dropped if the line holds 63
// or more bytes), then emits one summary with any_match, and clears all line
// state so a new stream may follow. The line store needs no clearing pass.
// One item is worked at a time; req_tready is high whenever the unit is idle
// (no replay, drop or summary pending), even while the last result still
// waits in the output register. Each result stalls as long as rsp_tready is low.
// Configure the pattern via csr_* only while the unit is idle.
module literal_line_grep_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] op
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] any_match, [15:9] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);
   import lglg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND,
      ST_NEWLINE,
      ST_DROP,
      ST_SUMMARY
   } state_type;

   // configuration registers
   logic [63:0]          pat_low_ff;
   logic [63:0]          pat_high_ff;
   logic [PAT_LEN_W-1:0] pat_len_ff;
   pat_type              pat;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= PAT_LEN_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAT_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PAT_HIGH: pat_high_ff <= csr_wdata;
            CSR_PAT_LEN:  pat_len_ff  <= csr_wdata[PAT_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign pat = {pat_high_ff, pat_low_ff};

   // control state
   state_type             state_ff,  state_in;
   logic [LINE_IDX_W-1:0] count_ff,  count_in;
   logic [LINE_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic                  hit_ff,    hit_in;
   logic                  ovf_ff,    ovf_in;
   logic                  seen_ff,   seen_in;
   logic                  end_ff,    end_in;
   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff,  rsp_kind_in;
   logic [7:0]            rsp_byte_ff,  rsp_byte_in;
   logic                  rsp_last_ff,  rsp_last_in;
   logic                  rsp_any_ff,   rsp_any_in;

   // line store
   logic [7:0]            line_mem [LINE_MAX];
   logic [7:0]            mem_q_ff;

   logic                  accept;
   logic                  is_end;
   logic                  is_nl;
   logic                  is_data;
   logic                  out_free;
   logic                  room;
   logic [LINE_IDX_W-1:0] count_next;
   logic                  win_ok;
   logic                  plen_valid;
   logic                  match_now;
   logic                  fits;
   win_ctl_type           win_ctl;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_end     = (req_tuser == OP_END);
   assign is_nl      = !is_end && (req_tdata == NEWLINE);
   assign is_data    = !is_end && !is_nl;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign room       = (count_ff < LINE_IDX_W'(LINE_MAX));
   assign count_next = room ? count_ff + LINE_IDX_W'(1) : count_ff;

   assign win_ctl.shift = accept && is_data;
   assign win_ctl.clear = accept && !is_data;
   assign win_ctl.data  = req_tdata;

   lglg_window u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (win_ctl),
      .pat    (pat),
      .plen   (pat_len_ff),
      .all_ok (win_ok)
   );

   assign plen_valid = (pat_len_ff != '0) && (pat_len_ff <= PAT_LEN_W'(PAT_MAX));
   assign match_now  = win_ok && plen_valid
                       && ({1'b0, count_next} >= (LINE_IDX_W+1)'(pat_len_ff));

   // end of input also needs room for the appended newline and the summary
   assign fits = is_end
                 ? (!ovf_ff && ((LINE_IDX_W+1)'(count_ff) <= (LINE_IDX_W+1)'(RESULT_LIMIT - 2)))
                 : !ovf_ff;

   always_ff @(posedge clock) begin
      if (accept && is_data && room) begin
         line_mem[count_ff] <= req_tdata;
      end
      if (state_ff == ST_READ) begin
         mem_q_ff <= line_mem[rd_idx_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      hit_in       = hit_ff;
      ovf_in       = ovf_ff;
      seen_in      = seen_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_any_in   = rsp_any_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_data) begin
                  count_in = count_next;
                  ovf_in   = ovf_ff || !room;
                  hit_in   = hit_ff || match_now;
               end else begin
                  end_in    = is_end;
                  rd_idx_in = '0;
                  hit_in    = 1'b0;
                  ovf_in    = 1'b0;
                  seen_in   = seen_ff || hit_ff;
                  if (hit_ff && fits) begin
                     state_in = ST_READ;
                  end else if (hit_ff) begin
                     state_in = ST_DROP;
                  end else if (is_end) begin
                     state_in = ST_SUMMARY;
                  end else begin
                     count_in = '0;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_BYTE;
               rsp_byte_in  = mem_q_ff;
               rsp_last_in  = 1'b0;
               rsp_any_in   = 1'b0;
               rd_idx_in    = rd_idx_ff + LINE_IDX_W'(1);
               if ((LINE_IDX_W+1)'(rd_idx_ff) + (LINE_IDX_W+1)'(1)
                   == (LINE_IDX_W+1)'(count_ff)) begin
                  state_in = ST_NEWLINE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_NEWLINE, ST_DROP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = (state_ff == ST_DROP) ? KIND_DROP : KIND_BYTE;
               rsp_byte_in  = (state_ff == ST_DROP) ? 8'h00 : NEWLINE;
               rsp_last_in  = !end_ff;
               rsp_any_in   = 1'b0;
               count_in     = '0;
               state_in     = end_ff ? ST_SUMMARY : ST_IDLE;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SUMMARY;
               rsp_byte_in  = 8'h00;
               rsp_last_in  = 1'b1;
               rsp_any_in   = seen_ff;
               seen_in      = 1'b0;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         hit_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         hit_ff       <= hit_in;
         ovf_ff       <= ovf_in;
         seen_ff      <= seen_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_any_ff  <= rsp_any_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_any_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
